// File: rtl/core/link_transport_arbiter_unit_macros.svh
// Assertion macros used by the port-level checker of the transport arbiter.
`ifndef LINK_TRANSPORT_ARBITER_UNIT_MACROS_SVH
`define LINK_TRANSPORT_ARBITER_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("link transport arbiter check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("link transport arbiter check failed");

`endif

// File: rtl/core/lta_pkg.sv
// Types and constants of the link transport arbiter.
package lta_pkg;

    // Item field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IN_W    = 40;
    localparam int unsigned OUT_W   = 8;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned APB_W   = 32;

    // Configuration register indexes
    localparam logic [1:0] REG_HEARTBEAT_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_PROBE_INTERVAL     = 2'd1;
    localparam logic [1:0] REG_PROBE_WINDOW       = 2'd2;
    localparam logic [1:0] REG_HEARTBEAT_INTERVAL = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_HEARTBEAT_TIMEOUT  = 16'd3000;
    localparam logic [CFG_W-1:0] RST_PROBE_INTERVAL     = 16'd10000;
    localparam logic [CFG_W-1:0] RST_PROBE_WINDOW       = 16'd500;
    localparam logic [CFG_W-1:0] RST_HEARTBEAT_INTERVAL = 16'd1000;

    // Sleep synchronisation command
    typedef enum logic [1:0] {
        SYNC_NONE  = 2'd0,
        SYNC_SLEEP = 2'd1,
        SYNC_WAKE  = 2'd2
    } sync_cmd_t;

    // One decoded input item
    typedef struct packed {
        logic              local_sleeping;
        logic              remote_connected;
        logic              peer_known;
        logic              station_connected;
        logic              serial_heartbeat_seen;
        logic [TIME_W-1:0] now_time;
    } in_item_t;

    // One result item
    typedef struct packed {
        sync_cmd_t sleep_sync_cmd;
        logic      send_heartbeat;
        logic      release_serial;
        logic      send_probe;
        logic      acquire_serial;
        logic      route_select;
    } out_item_t;

endpackage

// File: rtl/core/link_transport_arbiter_unit.sv
// Top level of the link transport arbiter: input stage, decision logic, result stage.
//
//  channel   | direction | handshake        | payload
//  ----------+-----------+------------------+------------------------------------------
//  s_*       | in        | tvalid / tready  | tick: time stamp and five status flags
//  m_*       | out       | tvalid / tready  | decision: route, serial and sync commands
//  APB       | in        | psel / penable   | four 16-bit timing registers
//
// An item is accepted into the input register and leaves through the result register,
// from which its result is offered; a stall on the result side can hold it in either.
// One item is taken every cycle while the result side keeps taking results.
// The decision and all state updates happen in the single step between the two registers.
// Reset clears the state, loads the default timings and empties both stages.
// With the result side stalled the block holds one item in each stage, then drops s_tready.
module link_transport_arbiter_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Fields from bit 0: now_time[31:0], serial_heartbeat_seen, station_connected,
    // peer_known, remote_connected, local_sleeping, zero padding[39:37]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lta_pkg::IN_W-1:0]      s_tdata,
    // Fields from bit 0: route_select, acquire_serial, send_probe, release_serial,
    // send_heartbeat, sleep_sync_cmd[6:5], zero padding[7]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lta_pkg::OUT_W-1:0]     m_tdata,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lta_pkg::ADDR_W-1:0]    paddr,
    input  logic [lta_pkg::APB_W-1:0]     pwdata,
    output logic [lta_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);
    import lta_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] hb_timeout_reg;
    logic [CFG_W-1:0] probe_interval_reg;
    logic [CFG_W-1:0] probe_window_reg;
    logic [CFG_W-1:0] hb_interval_reg;
    logic             cfg_write;
    logic [1:0]       reg_index;

    // Stage registers
    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    out_item_t        out_item_next;
    logic             advance;

    // Arbitration state
    logic [TIME_W-1:0] last_serial_beat_reg, last_serial_beat_next;
    logic              serial_ever_seen_reg, serial_ever_seen_next;
    logic [TIME_W-1:0] probe_window_end_reg, probe_window_end_next;
    logic [TIME_W-1:0] last_probe_time_reg, last_probe_time_next;
    logic [TIME_W-1:0] last_beat_sent_reg, last_beat_sent_next;
    logic              sleep_synced_reg, sleep_synced_next;
    logic              synced_sleep_mode_reg, synced_sleep_mode_next;

    // Decision terms
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] since_beat;
    logic [TIME_W-1:0] since_probe;
    logic [TIME_W-1:0] past_window;
    logic [TIME_W-1:0] since_sent;
    logic              fresh;
    logic              grace;
    logic              want_wireless;
    logic              probe_due;
    logic              window_closed;
    logic              beat_due;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_timeout_reg     <= RST_HEARTBEAT_TIMEOUT;
            probe_interval_reg <= RST_PROBE_INTERVAL;
            probe_window_reg   <= RST_PROBE_WINDOW;
            hb_interval_reg    <= RST_HEARTBEAT_INTERVAL;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_HEARTBEAT_TIMEOUT:  hb_timeout_reg     <= pwdata[CFG_W-1:0];
                REG_PROBE_INTERVAL:     probe_interval_reg <= pwdata[CFG_W-1:0];
                REG_PROBE_WINDOW:       probe_window_reg   <= pwdata[CFG_W-1:0];
                REG_HEARTBEAT_INTERVAL: hb_interval_reg    <= pwdata[CFG_W-1:0];
                default:                hb_interval_reg    <= hb_interval_reg;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        unique case (reg_index)
            REG_HEARTBEAT_TIMEOUT:  prdata = {{(APB_W-CFG_W){1'b0}}, hb_timeout_reg};
            REG_PROBE_INTERVAL:     prdata = {{(APB_W-CFG_W){1'b0}}, probe_interval_reg};
            REG_PROBE_WINDOW:       prdata = {{(APB_W-CFG_W){1'b0}}, probe_window_reg};
            REG_HEARTBEAT_INTERVAL: prdata = {{(APB_W-CFG_W){1'b0}}, hb_interval_reg};
            default:                prdata = '0;
        endcase
    end

    // Stage handshakes: the input stage moves on when the result stage is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_item_reg};

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item_t'(s_tdata[IN_W-4:0]);
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // Time differences, all modulo 2^32
    assign now         = in_item_reg.now_time;
    assign since_beat  = now - last_serial_beat_next;
    assign since_probe = now - last_probe_time_reg;
    assign past_window = now - probe_window_end_reg;
    assign since_sent  = now - last_beat_sent_reg;

    // Freshness of the serial link and the route choice
    always_comb
    begin
        last_serial_beat_next = in_item_reg.serial_heartbeat_seen ? now : last_serial_beat_reg;
        serial_ever_seen_next = serial_ever_seen_reg || in_item_reg.serial_heartbeat_seen;
        fresh = (last_serial_beat_next != '0)
             && (since_beat < {{(TIME_W-CFG_W){1'b0}}, hb_timeout_reg});
        grace = (last_serial_beat_next == '0)
             && (now < {{(TIME_W-CFG_W){1'b0}}, hb_timeout_reg});
        want_wireless = !fresh && !grace && in_item_reg.station_connected
                     && in_item_reg.peer_known && !serial_ever_seen_next;
        probe_due     = since_probe >= {{(TIME_W-CFG_W){1'b0}}, probe_interval_reg};
        window_closed = (probe_window_end_reg != '0) && !past_window[TIME_W-1];
        beat_due      = since_sent >= {{(TIME_W-CFG_W){1'b0}}, hb_interval_reg};
    end

    // Decision and next state
    always_comb
    begin
        out_item_next          = '0;
        out_item_next.sleep_sync_cmd = SYNC_NONE;
        probe_window_end_next  = probe_window_end_reg;
        last_probe_time_next   = last_probe_time_reg;
        last_beat_sent_next    = last_beat_sent_reg;
        sleep_synced_next      = sleep_synced_reg;
        synced_sleep_mode_next = synced_sleep_mode_reg;

        // Route and serial probing
        if (!want_wireless)
        begin
            probe_window_end_next        = '0;
            out_item_next.acquire_serial = 1'b1;
        end
        else
        begin
            out_item_next.route_select = 1'b1;
            priority if (probe_due)
            begin
                last_probe_time_next         = now;
                probe_window_end_next        = now + {{(TIME_W-CFG_W){1'b0}}, probe_window_reg};
                out_item_next.acquire_serial = 1'b1;
                out_item_next.send_probe     = 1'b1;
            end
            else if (window_closed)
            begin
                probe_window_end_next        = '0;
                out_item_next.release_serial = 1'b1;
            end
            else
            begin
                probe_window_end_next        = probe_window_end_reg;
            end
        end

        // Outgoing heartbeat
        if (beat_due)
        begin
            last_beat_sent_next          = now;
            out_item_next.send_heartbeat = 1'b1;
        end

        // Sleep synchronisation with the remote unit
        priority if (!in_item_reg.remote_connected)
        begin
            sleep_synced_next = 1'b0;
        end
        else if (!sleep_synced_reg || (in_item_reg.local_sleeping != synced_sleep_mode_reg))
        begin
            out_item_next.sleep_sync_cmd = in_item_reg.local_sleeping ? SYNC_SLEEP : SYNC_WAKE;
            sleep_synced_next            = 1'b1;
            synced_sleep_mode_next       = in_item_reg.local_sleeping;
        end
        else
        begin
            sleep_synced_next            = sleep_synced_reg;
        end
    end

    // State update, once per item leaving the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_serial_beat_reg  <= '0;
            serial_ever_seen_reg  <= 1'b0;
            probe_window_end_reg  <= '0;
            last_probe_time_reg   <= '0;
            last_beat_sent_reg    <= '0;
            sleep_synced_reg      <= 1'b0;
            synced_sleep_mode_reg <= 1'b0;
        end
        else if (advance)
        begin
            last_serial_beat_reg  <= last_serial_beat_next;
            serial_ever_seen_reg  <= serial_ever_seen_next;
            probe_window_end_reg  <= probe_window_end_next;
            last_probe_time_reg   <= last_probe_time_next;
            last_beat_sent_reg    <= last_beat_sent_next;
            sleep_synced_reg      <= sleep_synced_next;
            synced_sleep_mode_reg <= synced_sleep_mode_next;
        end
    end

endmodule

// File: rtl/core/lta_checker.sv
// Port-level checks of the link transport arbiter and their binding to the top level.
`include "link_transport_arbiter_unit_macros.svh"

module lta_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [lta_pkg::OUT_W-1:0] m_tdata
);
    import lta_pkg::*;

    out_item_t res;

    assign res = out_item_t'(m_tdata[OUT_W-2:0]);

    // A stalled result item keeps its value.
    `LTA_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The sync command never takes its unused code.
    `LTA_ASSERT_IMP(a_sync_code, clk, rst_n, m_tvalid, m_tdata[6:5] != 2'b11)

    // On the serial route the line is held and no probe or release is issued.
    `LTA_ASSERT_IMP(a_serial_route, clk, rst_n, m_tvalid && !res.route_select,
        res.acquire_serial && !res.send_probe && !res.release_serial)

    // A probe acquires the line, a release does not, and both belong to the wireless route.
    `LTA_ASSERT_IMP(a_probe_release, clk, rst_n,
        m_tvalid && (res.send_probe || res.release_serial),
        res.route_select && (res.send_probe == res.acquire_serial)
        && !(res.send_probe && res.release_serial))

endmodule

bind link_transport_arbiter_unit lta_checker u_lta_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/tb_link_transport_arbiter_unit.sv
// Self-checking testbench for the link transport arbiter: directed ticks, random time walks.
`timescale 1ns / 1ps

module tb_link_transport_arbiter_unit;

    import lta_pkg::*;

    // Cycles without any accepted item before the run is abandoned.
    localparam int unsigned STALL_LIMIT = 5000;
    // Cycles left after the last result so that a stray extra result is seen.
    localparam int unsigned TAIL_CYCLES = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // Fields from bit 0: now_time[31:0], serial_heartbeat_seen, station_connected,
    // peer_known, remote_connected, local_sleeping, zero padding[39:37]
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // Fields from bit 0: route_select, acquire_serial, send_probe, release_serial,
    // send_heartbeat, sleep_sync_cmd[6:5], zero padding[7]
    logic [OUT_W-1:0]     m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [APB_W-1:0]     pwdata;
    logic [APB_W-1:0]     prdata;
    logic                 pready;

    link_transport_arbiter_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Timing registers as the block should hold them, widened to the time width.
    logic [TIME_W-1:0] timing_regs [4];

    // Arbitration state as the block should hold it.
    logic [TIME_W-1:0] beat_rx_time;
    logic              serial_seen;
    logic [TIME_W-1:0] probe_end;
    logic [TIME_W-1:0] probe_start;
    logic [TIME_W-1:0] beat_tx_time;
    logic              sync_done;
    logic              sync_mode_sleep;

    // Decisions still owed by the block, oldest first.
    out_item_t         pending_decisions [$];

    int                fail_count;
    int unsigned       idle_cycles;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;

    // Stimulus state carried from one item to the next.
    logic [TIME_W-1:0] clock_ms;
    logic              remote_up;
    logic              asleep;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the decision for one tick and advance the expected state.
    function automatic out_item_t arbitrate(input in_item_t tick);
        out_item_t         res;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] since_end;
        logic              fresh;
        logic              grace;
        logic              wireless;
        res    = '0;
        now_ms = tick.now_time;
        if (tick.serial_heartbeat_seen)
        begin
            beat_rx_time = now_ms;
            serial_seen  = 1'b1;
        end
        fresh    = (beat_rx_time != '0) &&
                   ((now_ms - beat_rx_time) < timing_regs[REG_HEARTBEAT_TIMEOUT]);
        grace    = (beat_rx_time == '0) && (now_ms < timing_regs[REG_HEARTBEAT_TIMEOUT]);
        wireless = !fresh && !grace && tick.station_connected && tick.peer_known &&
                   !serial_seen;

        // Route choice, probe scheduling and window close.
        if (!wireless)
        begin
            probe_end          = '0;
            res.acquire_serial = 1'b1;
        end
        else
        begin
            res.route_select = 1'b1;
            since_end        = now_ms - probe_end;
            if ((now_ms - probe_start) >= timing_regs[REG_PROBE_INTERVAL])
            begin
                probe_start        = now_ms;
                probe_end          = now_ms + timing_regs[REG_PROBE_WINDOW];
                res.acquire_serial = 1'b1;
                res.send_probe     = 1'b1;
            end
            else if (probe_end != '0 && !since_end[TIME_W-1])
            begin
                res.release_serial = 1'b1;
                probe_end          = '0;
            end
        end

        // Outgoing heartbeat gate.
        if ((now_ms - beat_tx_time) >= timing_regs[REG_HEARTBEAT_INTERVAL])
        begin
            beat_tx_time       = now_ms;
            res.send_heartbeat = 1'b1;
        end

        // Sleep or wake sync on reconnect or on a change of mode.
        if (!tick.remote_connected)
        begin
            sync_done = 1'b0;
        end
        else if (!sync_done || tick.local_sleeping != sync_mode_sleep)
        begin
            res.sleep_sync_cmd = tick.local_sleeping ? SYNC_SLEEP : SYNC_WAKE;
            sync_done          = 1'b1;
            sync_mode_sleep    = tick.local_sleeping;
        end
        return res;
    endfunction

    function automatic in_item_t tick_of(input logic [TIME_W-1:0] t, input logic beat,
                                         input logic sta, input logic peer,
                                         input logic remote, input logic sleeping);
        in_item_t tick;
        tick.now_time              = t;
        tick.serial_heartbeat_seen = beat;
        tick.station_connected     = sta;
        tick.peer_known            = peer;
        tick.remote_connected      = remote;
        tick.local_sleeping        = sleeping;
        return tick;
    endfunction

    // Offer one tick, starting at a falling edge; returns at the falling edge after
    // acceptance with tvalid still high, so back-to-back items need no bubble.
    task automatic send_tick(input in_item_t tick);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - $bits(in_item_t)){1'b0}}, tick};
        do
            @(posedge clk);
        while (!s_tready);
        pending_decisions.push_back(arbitrate(tick));
        @(negedge clk);
    endtask

    // Stop offering ticks and wait, at falling edges, until every decision has come.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // One register write, then a read back of the same register; each has a setup
    // phase and an access phase. Ends at the reading edge.
    task automatic program_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // Upper bits are junk: only the low sixteen are kept.
        pwdata  <= {16'($urandom_range(0, 65535)), value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        timing_regs[idx] = {{(TIME_W-CFG_W){1'b0}}, value};
        // Read the register back.
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata != timing_regs[idx])
        begin
            $error("prdata: expected %0d, got %0d", timing_regs[idx], prdata);
            fail_count++;
        end
    endtask

    // Drain the block, then load all four timings; ends at a falling edge.
    task automatic retime(input logic [CFG_W-1:0] t_out, input logic [CFG_W-1:0] p_int,
                          input logic [CFG_W-1:0] p_win, input logic [CFG_W-1:0] hb_int);
        drain();
        program_reg(REG_HEARTBEAT_TIMEOUT, t_out);
        program_reg(REG_PROBE_INTERVAL, p_int);
        program_reg(REG_PROBE_WINDOW, p_win);
        program_reg(REG_HEARTBEAT_INTERVAL, hb_int);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hand-picked ticks at the reset timings, before any serial heartbeat is seen.
    task automatic test_directed_ticks;
        // Grace period, then the first wireless tick without a probe.
        send_tick(tick_of(32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_of(32'd2999, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        send_tick(tick_of(32'd3000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        // Probe, window still open, window end reached.
        send_tick(tick_of(32'd10000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(tick_of(32'd10499, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(tick_of(32'd10500, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        // Peer lost drops back to serial; a new probe after it, remote dropping out.
        send_tick(tick_of(32'd20500, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(tick_of(32'd20600, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        send_tick(tick_of(32'd20700, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(tick_of(32'd20800, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        // Probe whose window end wraps to zero: that window never closes.
        send_tick(tick_of(32'hFFFF_FE0C, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(tick_of(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(tick_of(32'h0000_1000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(tick_of(32'h0000_2000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        // Time running backwards looks like a long gap to the probe timer.
        send_tick(tick_of(32'd5000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(tick_of(32'd5000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
        send_tick(tick_of(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_tick(tick_of(32'h8000_0000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        clock_ms = 32'h8000_0000;
    endtask

    // Random walk of time with no serial heartbeat, so the wireless route stays open.
    task automatic test_wireless_walk(input int count, input int unsigned max_step);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                clock_ms = $urandom();
            else
                clock_ms += $urandom_range(0, max_step);
            if ($urandom_range(0, 99) < 10)
                remote_up = ~remote_up;
            if ($urandom_range(0, 99) < 15)
                asleep = ~asleep;
            send_tick(tick_of(clock_ms, 1'b0, $urandom_range(0, 99) < 90,
                              $urandom_range(0, 99) < 90, remote_up, asleep));
        end
    endtask

    // Serial heartbeats: one at time zero, freshness edges, then a random walk.
    task automatic test_serial_heartbeats(input int count, input int unsigned max_step);
        send_tick(tick_of(32'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(tick_of(32'd5000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(tick_of(32'd100, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(tick_of(32'd2099, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(tick_of(32'd2100, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        clock_ms = 32'd2100;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                clock_ms = $urandom();
            else
                clock_ms += $urandom_range(0, max_step);
            if ($urandom_range(0, 99) < 10)
                remote_up = ~remote_up;
            if ($urandom_range(0, 99) < 15)
                asleep = ~asleep;
            send_tick(tick_of(clock_ms, $urandom_range(0, 99) < 20,
                              $urandom_range(0, 99) < 90, $urandom_range(0, 99) < 90,
                              remote_up, asleep));
        end
    endtask

    // Result side: random back-pressure, changed at falling edges.
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare every accepted result with the oldest pending decision.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_decisions.size() == 0)
            begin
                $error("result item with no tick pending: m_tdata 0x%02h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_decisions.pop_front();
                got  = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
                check_field("route_select", {1'b0, want.route_select},
                            {1'b0, got.route_select});
                check_field("acquire_serial", {1'b0, want.acquire_serial},
                            {1'b0, got.acquire_serial});
                check_field("send_probe", {1'b0, want.send_probe}, {1'b0, got.send_probe});
                check_field("release_serial", {1'b0, want.release_serial},
                            {1'b0, got.release_serial});
                check_field("send_heartbeat", {1'b0, want.send_heartbeat},
                            {1'b0, got.send_heartbeat});
                check_field("sleep_sync_cmd", want.sleep_sync_cmd, got.sleep_sync_cmd);
                check_field("padding", 2'b00, {1'b0, m_tdata[OUT_W-1]});
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        fail_count    = 0;
        idle_cycles   = 0;
        send_idle_pct = 30;
        recv_idle_pct = 72;
        clock_ms      = '0;
        remote_up     = 1'b1;
        asleep        = 1'b0;

        timing_regs[REG_HEARTBEAT_TIMEOUT]  = {{(TIME_W-CFG_W){1'b0}}, RST_HEARTBEAT_TIMEOUT};
        timing_regs[REG_PROBE_INTERVAL]     = {{(TIME_W-CFG_W){1'b0}}, RST_PROBE_INTERVAL};
        timing_regs[REG_PROBE_WINDOW]       = {{(TIME_W-CFG_W){1'b0}}, RST_PROBE_WINDOW};
        timing_regs[REG_HEARTBEAT_INTERVAL] = {{(TIME_W-CFG_W){1'b0}}, RST_HEARTBEAT_INTERVAL};
        beat_rx_time    = '0;
        serial_seen     = 1'b0;
        probe_end       = '0;
        probe_start     = '0;
        beat_tx_time    = '0;
        sync_done       = 1'b0;
        sync_mode_sleep = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly, receiver stalls heavily; reset timings.
        test_directed_ticks();
        test_wireless_walk(300, 1500);

        // Roles swapped: the sender idles heavily. Smallest nonzero, then largest timings.
        send_idle_pct = 72;
        recv_idle_pct = 30;
        retime(16'd1, 16'd1, 16'd1, 16'd1);
        test_wireless_walk(250, 3);
        retime(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        clock_ms = 32'hFFF0_0000;
        test_wireless_walk(250, 40000);

        // No idling at all. Zero timings, random timings, then serial heartbeats.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        retime(16'd0, 16'd0, 16'd0, 16'd0);
        test_wireless_walk(150, 5);
        retime(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 5000)),
               16'($urandom_range(1, 5000)), 16'($urandom_range(1, 5000)));
        test_wireless_walk(300, 2000);
        retime(16'd2000, 16'd8000, 16'd300, 16'd700);
        test_serial_heartbeats(250, 1500);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
